// ----- hw/rtl/grid_nearest_cell_search_assert.svh -----
// assertion macros used by gncs_checker, the port-level checker of the grid search
`ifndef GRID_NEAREST_CELL_SEARCH_ASSERT_SVH
`define GRID_NEAREST_CELL_SEARCH_ASSERT_SVH

// same-cycle implication, disabled while rstn is low
`define GNCS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("grid search check failed");

// next-cycle implication, disabled while rstn is low
`define GNCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("grid search check failed");

`endif

// ----- hw/rtl/gncs_pkg.sv -----
// types and constants of the grid nearest cell search
`default_nettype none
package gncs_pkg;

    localparam int MAX_DIM   = 32;
    localparam int KIND_BITS = 3;
    localparam int ID_BITS   = 8;

    localparam int COORD_W   = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int EFF_W     = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int GRID_REG_W = 6;
    localparam int CFG_IDX_W = 1;

    // field widths on the stream ports
    localparam int F_COORD_W = 5;
    localparam int F_KIND_W  = 3;
    localparam int F_ID_W    = 8;
    localparam int TDATA_W   = 24;
    localparam int IN_USER_W = 2;
    localparam int OUT_USER_W = 2;

    // operation codes
    localparam logic [1:0] OP_READ         = 2'd0;
    localparam logic [1:0] OP_WRITE        = 2'd1;
    localparam logic [1:0] OP_NEAR_EMPTY   = 2'd2;
    localparam logic [1:0] OP_NEAR_KIND    = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OOB       = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    typedef struct packed {
        logic                 occupied;
        logic [KIND_BITS-1:0] kind;
        logic [ID_BITS-1:0]   occupant_id;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    typedef struct packed {
        logic                 start;
        logic                 cand_valid;
        logic                 kind_search;
        logic [KIND_BITS-1:0] want_kind;
        logic [COORD_W-1:0]   query_x;
        logic [COORD_W-1:0]   query_y;
        logic [COORD_W-1:0]   cand_x;
        logic [COORD_W-1:0]   cand_y;
    } srch_ctrl_t;

    typedef struct packed {
        logic               have;
        logic [COORD_W-1:0] best_x;
        logic [COORD_W-1:0] best_y;
        cell_t              best_cell;
    } srch_res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/gncs_cell_store.sv -----
// cell memory: one write port, one registered read port
`default_nettype none
module gncs_cell_store (
    input  wire logic                   aclk,
    input  wire logic                   wr_en,
    input  wire logic [gncs_pkg::ADDR_W-1:0] wr_addr,
    input  wire gncs_pkg::cell_t        wr_data,
    input  wire logic                   rd_en,
    input  wire logic [gncs_pkg::ADDR_W-1:0] rd_addr,
    output gncs_pkg::cell_t             rd_data
);
    import gncs_pkg::*;

    cell_t mem [(1 << ADDR_W)];
    cell_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/gncs_search.sv -----
// distance compare and best-cell tracking for the scan
`default_nettype none
module gncs_search (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire gncs_pkg::srch_ctrl_t ctrl,
    input  wire gncs_pkg::cell_t      cand_cell,
    output gncs_pkg::srch_res_t       res
);
    import gncs_pkg::*;

    logic               have_reg;
    logic [DIST_W-1:0]  best_d_reg;
    logic [COORD_W-1:0] best_x_reg;
    logic [COORD_W-1:0] best_y_reg;
    cell_t              best_cell_reg;

    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;
    logic [SQ_W-1:0]    sqx;
    logic [SQ_W-1:0]    sqy;
    logic [DIST_W-1:0]  cand_d;
    logic               match;
    logic               take;

    always_comb begin
        adx = (ctrl.query_x >= ctrl.cand_x) ? ctrl.query_x - ctrl.cand_x
                                            : ctrl.cand_x - ctrl.query_x;
        ady = (ctrl.query_y >= ctrl.cand_y) ? ctrl.query_y - ctrl.cand_y
                                            : ctrl.cand_y - ctrl.query_y;
        sqx    = SQ_W'(adx) * SQ_W'(adx);
        sqy    = SQ_W'(ady) * SQ_W'(ady);
        cand_d = DIST_W'(sqx) + DIST_W'(sqy);
        if (ctrl.kind_search) begin
            match = cand_cell.occupied && (cand_cell.kind == ctrl.want_kind);
        end else begin
            match = !cand_cell.occupied;
        end
        // strictly nearer only, so the first cell in raster order keeps a tie
        take = ctrl.cand_valid && match && (!have_reg || (cand_d < best_d_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (ctrl.start) begin
            have_reg <= 1'b0;
        end else if (take) begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_d_reg    <= cand_d;
            best_x_reg    <= ctrl.cand_x;
            best_y_reg    <= ctrl.cand_y;
            best_cell_reg <= cand_cell;
        end
    end

    assign res.have      = have_reg;
    assign res.best_x    = best_x_reg;
    assign res.best_y    = best_y_reg;
    assign res.best_cell = best_cell_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/grid_nearest_cell_search.sv -----
// top level: sequencer, cell memory and scan for the grid nearest cell search
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tuser op, s_tdata cell and query fields
// m_        out  m_tvalid/m_tready  m_tuser status, m_tdata cell found or read
// cfg_wr_   in   cfg_wr_en          cfg_wr_addr register index, cfg_wr_data value
//
// after reset a clearing pass writes all 1024 cells empty, with s_tready low
// one item at a time: s_tready stays low from acceptance until the result is loaded into the output register
// a search is bound by the single memory read port, one cell per cycle
// the output register lets the next item be taken while a result waits on m_tready
`default_nettype none
module grid_nearest_cell_search (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op
    input  wire logic [gncs_pkg::IN_USER_W-1:0] s_tuser,
    // cell_x, cell_y, new_occupied, kind, new_occupant_id
    input  wire logic [gncs_pkg::TDATA_W-1:0]   s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status
    output logic [gncs_pkg::OUT_USER_W-1:0]     m_tuser,
    // found_x, found_y, found_occupied, found_kind, found_occupant_id
    output logic [gncs_pkg::TDATA_W-1:0]        m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [gncs_pkg::CFG_IDX_W-1:0] cfg_wr_addr,
    input  wire logic [gncs_pkg::GRID_REG_W-1:0] cfg_wr_data
);
    import gncs_pkg::*;

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_EXEC    = 3'd2;
    localparam logic [2:0] ST_RDWAIT  = 3'd3;
    localparam logic [2:0] ST_SCAN    = 3'd4;
    localparam logic [2:0] ST_DRAIN   = 3'd5;
    localparam logic [2:0] ST_COLLECT = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [GRID_REG_W-1:0] grid_width_reg;
    logic [GRID_REG_W-1:0] grid_height_reg;

    logic [1:0]            op_reg;
    logic [COORD_W-1:0]    px_reg;
    logic [COORD_W-1:0]    py_reg;
    cell_t                 new_cell_reg;

    logic [COORD_W-1:0]    scan_x_reg, scan_x_next;
    logic [COORD_W-1:0]    scan_y_reg, scan_y_next;
    logic [COORD_W-1:0]    cand_x_reg;
    logic [COORD_W-1:0]    cand_y_reg;
    logic                  issue_reg;

    logic [1:0]            res_status_reg, res_status_next;
    logic [COORD_W-1:0]    res_x_reg, res_x_next;
    logic [COORD_W-1:0]    res_y_reg, res_y_next;
    cell_t                 res_cell_reg, res_cell_next;

    logic                  out_valid_reg;
    logic [TDATA_W-1:0]    out_tdata_reg;
    logic [OUT_USER_W-1:0] out_tuser_reg;

    logic [EFF_W-1:0]      w_eff;
    logic [EFF_W-1:0]      h_eff;
    logic                  in_bounds;
    logic                  scan_last;
    logic                  accept;
    logic                  out_load;

    logic                  mem_wr_en;
    logic [ADDR_W-1:0]     mem_wr_addr;
    cell_t                 mem_wr_data;
    logic                  mem_rd_en;
    logic [ADDR_W-1:0]     mem_rd_addr;
    cell_t                 mem_rd_data;

    logic                  srch_start;
    srch_ctrl_t            srch_ctrl;
    srch_res_t             srch_res;

    // registers above the grid size act as the full grid
    assign w_eff = (int'(grid_width_reg) > MAX_DIM) ? EFF_W'(MAX_DIM)
                                                    : EFF_W'(grid_width_reg);
    assign h_eff = (int'(grid_height_reg) > MAX_DIM) ? EFF_W'(MAX_DIM)
                                                     : EFF_W'(grid_height_reg);
    assign in_bounds = (EFF_W'(px_reg) < w_eff) && (EFF_W'(py_reg) < h_eff);
    assign scan_last = (EFF_W'(scan_x_reg) == w_eff - EFF_W'(1))
                    && (EFF_W'(scan_y_reg) == h_eff - EFF_W'(1));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next      = state_reg;
        scan_x_next     = scan_x_reg;
        scan_y_next     = scan_y_reg;
        res_status_next = res_status_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_cell_next   = res_cell_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = {py_reg, px_reg};
        mem_wr_data     = new_cell_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = {py_reg, px_reg};
        srch_start      = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = '0;
                if (&clr_addr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_status_next = STATUS_OK;
                res_x_next      = px_reg;
                res_y_next      = py_reg;
                res_cell_next   = new_cell_reg;
                unique case (op_reg)
                    OP_READ, OP_WRITE: begin
                        if (!in_bounds) begin
                            res_status_next = STATUS_OOB;
                            res_x_next      = '0;
                            res_y_next      = '0;
                            res_cell_next   = '0;
                            state_next      = ST_FINISH;
                        end else if (op_reg == OP_WRITE) begin
                            mem_wr_en  = 1'b1;
                            state_next = ST_FINISH;
                        end else begin
                            mem_rd_en  = 1'b1;
                            state_next = ST_RDWAIT;
                        end
                    end
                    OP_NEAR_EMPTY, OP_NEAR_KIND: begin
                        if ((w_eff == '0) || (h_eff == '0)) begin
                            res_status_next = STATUS_NOT_FOUND;
                            res_x_next      = '0;
                            res_y_next      = '0;
                            res_cell_next   = '0;
                            state_next      = ST_FINISH;
                        end else begin
                            srch_start  = 1'b1;
                            scan_x_next = '0;
                            scan_y_next = '0;
                            state_next  = ST_SCAN;
                        end
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_RDWAIT: begin
                res_cell_next = mem_rd_data;
                state_next    = ST_FINISH;
            end
            ST_SCAN: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = {scan_y_reg, scan_x_reg};
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end else if (EFF_W'(scan_x_reg) == w_eff - EFF_W'(1)) begin
                    scan_x_next = '0;
                    scan_y_next = scan_y_reg + COORD_W'(1);
                end else begin
                    scan_x_next = scan_x_reg + COORD_W'(1);
                end
            end
            ST_DRAIN: begin
                // last cell is being compared this cycle
                state_next = ST_COLLECT;
            end
            ST_COLLECT: begin
                if (srch_res.have) begin
                    res_status_next = STATUS_OK;
                    res_x_next      = srch_res.best_x;
                    res_y_next      = srch_res.best_y;
                    res_cell_next   = srch_res.best_cell;
                end else begin
                    res_status_next = STATUS_NOT_FOUND;
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_cell_next   = '0;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign srch_ctrl.start       = srch_start;
    assign srch_ctrl.cand_valid  = issue_reg;
    assign srch_ctrl.kind_search = (op_reg == OP_NEAR_KIND);
    assign srch_ctrl.want_kind   = new_cell_reg.kind;
    assign srch_ctrl.query_x     = px_reg;
    assign srch_ctrl.query_y     = py_reg;
    assign srch_ctrl.cand_x      = cand_x_reg;
    assign srch_ctrl.cand_y      = cand_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            grid_width_reg  <= GRID_REG_W'(32);
            grid_height_reg <= GRID_REG_W'(32);
            issue_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cfg_wr_en) begin
                unique case (cfg_wr_addr)
                    REG_GRID_WIDTH:  grid_width_reg  <= cfg_wr_data;
                    REG_GRID_HEIGHT: grid_height_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            issue_reg <= (state_reg == ST_SCAN);
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg                   <= s_tuser[1:0];
            px_reg                   <= s_tdata[4:0];
            py_reg                   <= s_tdata[9:5];
            new_cell_reg.occupied    <= s_tdata[10];
            new_cell_reg.kind        <= s_tdata[13:11];
            new_cell_reg.occupant_id <= s_tdata[21:14];
        end
        scan_x_reg     <= scan_x_next;
        scan_y_reg     <= scan_y_next;
        cand_x_reg     <= scan_x_reg;
        cand_y_reg     <= scan_y_reg;
        res_status_reg <= res_status_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_cell_reg   <= res_cell_next;
        if (out_load) begin
            out_tuser_reg <= res_status_reg;
            out_tdata_reg <= {2'b00,
                              F_ID_W'(res_cell_reg.occupant_id),
                              F_KIND_W'(res_cell_reg.kind),
                              res_cell_reg.occupied,
                              F_COORD_W'(res_y_reg),
                              F_COORD_W'(res_x_reg)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_tuser_reg;
    assign m_tdata  = out_tdata_reg;

    gncs_cell_store u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    gncs_search u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (srch_ctrl),
        .cand_cell (mem_rd_data),
        .res       (srch_res)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/gncs_checker.sv -----
// port-level checks for the grid nearest cell search, bound to the top level
`default_nettype none
`include "grid_nearest_cell_search_assert.svh"
module gncs_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic [gncs_pkg::IN_USER_W-1:0]  s_tuser,
    input wire logic [gncs_pkg::TDATA_W-1:0]    s_tdata,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [gncs_pkg::OUT_USER_W-1:0] m_tuser,
    input wire logic [gncs_pkg::TDATA_W-1:0]    m_tdata
);
    import gncs_pkg::*;

    // a stalled result holds
    `GNCS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // error results carry no cell contents
    `GNCS_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_tvalid && (m_tuser != STATUS_OK), m_tdata == '0)
    // one item in flight: busy the cycle after a transfer in
    `GNCS_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // reset starts the clearing pass with nothing offered or accepted
    `GNCS_ASSERT_NEXT(a_reset_quiet, aclk, 1'b1, !aresetn, !s_tready && !m_tvalid)

    logic unused_in;
    assign unused_in = ^{s_tuser, s_tdata};

endmodule

bind grid_nearest_cell_search gncs_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- dv/grid_search_checker.sv -----
// checker for the grid nearest cell search: keeps its own copy of the grid and compares results
`timescale 1ns / 1ps

module grid_search_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // op
    input  logic [gncs_pkg::IN_USER_W-1:0]    s_tuser,
    // cell_x, cell_y, new_occupied, kind, new_occupant_id
    input  logic [gncs_pkg::TDATA_W-1:0]      s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // status
    input  logic [gncs_pkg::OUT_USER_W-1:0]   m_tuser,
    // found_x, found_y, found_occupied, found_kind, found_occupant_id
    input  logic [gncs_pkg::TDATA_W-1:0]      m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [gncs_pkg::CFG_IDX_W-1:0]    cfg_wr_addr,
    input  logic [gncs_pkg::GRID_REG_W-1:0]   cfg_wr_data,
    output int                                fail_count,
    output int                                pending_count
);
    import gncs_pkg::*;

    typedef struct packed {
        logic [1:0]           status;
        logic [F_COORD_W-1:0] cell_x;
        logic [F_COORD_W-1:0] cell_y;
        cell_t                contents;
    } search_answer_t;

    cell_t                 grid_cells [MAX_DIM*MAX_DIM];
    logic [GRID_REG_W-1:0] width_reg;
    logic [GRID_REG_W-1:0] height_reg;
    search_answer_t        answers_q [$];
    int                    errors_seen = 0;

    // registers above the grid size act as the full grid
    function automatic int unsigned clamp_dim(logic [GRID_REG_W-1:0] reg_value);
        return (reg_value > MAX_DIM) ? MAX_DIM : reg_value;
    endfunction

    // works out the result of one item and applies a write to the grid copy
    function automatic search_answer_t apply_item(logic [1:0] op,
                                                  logic [F_COORD_W-1:0] qx,
                                                  logic [F_COORD_W-1:0] qy,
                                                  logic occ,
                                                  logic [F_KIND_W-1:0] kind,
                                                  logic [F_ID_W-1:0] id);
        search_answer_t answer;
        int unsigned    w, h, idx, best_d, d, cx, cy, best_x, best_y;
        int             dx, dy;
        bit             have, match;
        answer = '0;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (op == OP_READ || op == OP_WRITE) begin
            if (qx >= w || qy >= h) begin
                answer.status = STATUS_OOB;
                return answer;
            end
            idx = qy * MAX_DIM + qx;
            if (op == OP_WRITE) begin
                grid_cells[idx] = {occ, kind, id};
            end
            answer.status   = STATUS_OK;
            answer.cell_x   = qx;
            answer.cell_y   = qy;
            answer.contents = grid_cells[idx];
            return answer;
        end
        // raster scan, strictly nearer replaces so the first cell wins a tie
        have = 0;
        best_d = 0;
        best_x = 0;
        best_y = 0;
        for (cy = 0; cy < h; cy++) begin
            for (cx = 0; cx < w; cx++) begin
                idx = cy * MAX_DIM + cx;
                if (op == OP_NEAR_EMPTY)
                    match = !grid_cells[idx].occupied;
                else
                    match = grid_cells[idx].occupied && grid_cells[idx].kind == kind;
                if (match) begin
                    dx = int'(qx) - int'(cx);
                    dy = int'(qy) - int'(cy);
                    d = unsigned'(dx * dx + dy * dy);
                    if (!have || d < best_d) begin
                        have = 1;
                        best_d = d;
                        best_x = cx;
                        best_y = cy;
                    end
                end
            end
        end
        if (!have) begin
            answer.status = STATUS_NOT_FOUND;
            return answer;
        end
        answer.status   = STATUS_OK;
        answer.cell_x   = best_x[F_COORD_W-1:0];
        answer.cell_y   = best_y[F_COORD_W-1:0];
        answer.contents = grid_cells[best_y * MAX_DIM + best_x];
        return answer;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors_seen++;
        end
    endfunction

    always @(posedge aclk) begin
        search_answer_t want;
        if (!aresetn) begin
            foreach (grid_cells[i]) grid_cells[i] = '0;
            width_reg  = GRID_REG_W'(MAX_DIM);
            height_reg = GRID_REG_W'(MAX_DIM);
            answers_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_addr)
                    REG_GRID_WIDTH:  width_reg  = cfg_wr_data;
                    REG_GRID_HEIGHT: height_reg = cfg_wr_data;
                    default: ;
                endcase
            end
            // results first, so a result meeting an empty store is flagged
            if (m_tvalid && m_tready) begin
                if (answers_q.size() == 0) begin
                    $error("result transfer with no result outstanding: status %0d data %h",
                           m_tuser, m_tdata);
                    errors_seen++;
                end else begin
                    want = answers_q.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("found_x", 32'(want.cell_x), 32'(m_tdata[4:0]));
                    check_field("found_y", 32'(want.cell_y), 32'(m_tdata[9:5]));
                    check_field("found_occupied", 32'(want.contents.occupied),
                                32'(m_tdata[10]));
                    check_field("found_kind", 32'(want.contents.kind), 32'(m_tdata[13:11]));
                    check_field("found_occupant_id", 32'(want.contents.occupant_id),
                                32'(m_tdata[21:14]));
                end
            end
            if (s_tvalid && s_tready) begin
                answers_q.push_back(apply_item(s_tuser, s_tdata[4:0], s_tdata[9:5],
                                               s_tdata[10], s_tdata[13:11], s_tdata[21:14]));
            end
        end
        pending_count <= answers_q.size();
        fail_count    <= errors_seen;
    end

endmodule

// ----- dv/testbench.sv -----
// testbench top for the grid nearest cell search: stimulus, reset, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
    import gncs_pkg::*;

    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 16;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic [TDATA_W-1:0]    s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_USER_W-1:0] m_tuser;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_addr = '0;
    logic [GRID_REG_W-1:0] cfg_wr_data = '0;

    int          fail_count;
    int          pending_count;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          quiet_cycles = 0;
    int unsigned area_w = MAX_DIM;
    int unsigned area_h = MAX_DIM;

    grid_nearest_cell_search dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    grid_search_checker cell_search_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tuser       (s_tuser),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tuser       (m_tuser),
        .m_tdata       (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_addr   (cfg_wr_addr),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // ends the run if nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [4:0] x, input logic [4:0] y,
                             input logic occ, input logic [2:0] kind, input logic [7:0] id);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, id, kind, occ, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_all_answered();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic resize_grid(input int unsigned w, input int unsigned h);
        wait_all_answered();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= REG_GRID_WIDTH;
        cfg_wr_data <= w[GRID_REG_W-1:0];
        @(posedge aclk);
        cfg_wr_addr <= REG_GRID_HEIGHT;
        cfg_wr_data <= h[GRID_REG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        area_w = (w > MAX_DIM) ? MAX_DIM : w;
        area_h = (h > MAX_DIM) ? MAX_DIM : h;
    endtask

    // mostly coordinates inside the area in use, the rest anywhere
    task automatic send_random_item();
        logic [1:0] op;
        logic [4:0] x, y;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            op = OP_WRITE;
        else if (roll < 55)
            op = OP_READ;
        else if (roll < 75)
            op = OP_NEAR_EMPTY;
        else
            op = OP_NEAR_KIND;
        if (area_w != 0 && $urandom_range(0, 9) < 8)
            x = 5'($urandom_range(0, area_w - 1));
        else
            x = 5'($urandom_range(0, 31));
        if (area_h != 0 && $urandom_range(0, 9) < 8)
            y = 5'($urandom_range(0, area_h - 1));
        else
            y = 5'($urandom_range(0, 31));
        send_item(op, x, y, $urandom_range(0, 9) < 7, 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input int unsigned w, input int unsigned h,
                             input int idle_pct, input int stall_pct, input int count);
        resize_grid(w, h);
        sender_idle_pct = idle_pct;
        receiver_stall_pct <= stall_pct;
        repeat (count) send_random_item();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // freshly cleared grid, full size
        send_item(OP_READ, 5'd0, 5'd0, 1'b0, 3'd0, 8'd0);
        send_item(OP_NEAR_EMPTY, 5'd31, 5'd31, 1'b0, 3'd0, 8'd0);
        send_item(OP_NEAR_KIND, 5'd0, 5'd0, 1'b0, 3'd5, 8'd0);
        send_item(OP_WRITE, 5'd31, 5'd31, 1'b1, 3'd7, 8'd255);
        send_item(OP_WRITE, 5'd0, 5'd0, 1'b1, 3'd0, 8'd0);
        // empty cell that still carries a kind and id
        send_item(OP_WRITE, 5'd31, 5'd0, 1'b0, 3'd6, 8'hAA);
        send_item(OP_READ, 5'd31, 5'd31, 1'b0, 3'd0, 8'd0);
        send_item(OP_READ, 5'd31, 5'd0, 1'b0, 3'd0, 8'd0);
        send_item(OP_NEAR_KIND, 5'd0, 5'd0, 1'b0, 3'd7, 8'd0);
        // (1,0) and (0,1) tie, raster order picks (1,0)
        send_item(OP_NEAR_EMPTY, 5'd0, 5'd0, 1'b1, 3'd0, 8'd0);
        send_item(OP_NEAR_EMPTY, 5'd31, 5'd0, 1'b0, 3'd0, 8'd0);
        send_item(OP_WRITE, 5'd2, 5'd2, 1'b1, 3'd3, 8'h55);
        send_item(OP_WRITE, 5'd4, 5'd2, 1'b1, 3'd3, 8'h66);
        send_item(OP_NEAR_KIND, 5'd3, 5'd2, 1'b0, 3'd3, 8'd0);

        // small area: out of bounds, query from outside the grid
        resize_grid(5, 3);
        send_item(OP_READ, 5'd5, 5'd0, 1'b0, 3'd0, 8'd0);
        send_item(OP_WRITE, 5'd0, 5'd3, 1'b1, 3'd2, 8'h12);
        send_item(OP_WRITE, 5'd31, 5'd31, 1'b1, 3'd1, 8'd1);
        send_item(OP_NEAR_KIND, 5'd31, 5'd31, 1'b0, 3'd7, 8'd0);
        send_item(OP_NEAR_EMPTY, 5'd20, 5'd20, 1'b0, 3'd0, 8'd0);

        // oversized registers, earlier contents must reappear
        resize_grid(63, 40);
        send_item(OP_READ, 5'd31, 5'd31, 1'b0, 3'd0, 8'd0);
        send_item(OP_WRITE, 5'd31, 5'd31, 1'b0, 3'd2, 8'h11);

        // zero width then zero height: no cells at all
        resize_grid(0, 5);
        send_item(OP_READ, 5'd0, 5'd0, 1'b0, 3'd0, 8'd0);
        send_item(OP_NEAR_EMPTY, 5'd0, 5'd0, 1'b0, 3'd0, 8'd0);
        send_item(OP_WRITE, 5'd0, 5'd0, 1'b1, 3'd4, 8'h77);
        resize_grid(3, 0);
        send_item(OP_NEAR_KIND, 5'd1, 5'd1, 1'b0, 3'd0, 8'd0);

        run_phase(32, 32, 0, 0, 80);
        run_phase(4, 4, 46, 0, 70);
        run_phase(1, 1, 0, 46, 50);
        run_phase(7, 3, 21, 21, 70);
        run_phase(63, 40, 0, 0, 60);
        run_phase(0, 5, 46, 0, 30);
        run_phase(16, 9, 0, 46, 80);
        run_phase(2, 32, 21, 21, 70);
        run_phase(5, 32, 0, 0, 70);

        wait_all_answered();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
